FILE: src/ogrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogrc_pkg
// Shared constants and types of the occupancy grid ray cast block.
// ----------------------------------------------------------------------------
package ogrc_pkg;

	localparam int MAX_WIDTH     = 512;
	localparam int MAX_HEIGHT    = 512;
	localparam int MAP_CELLS     = MAX_WIDTH * MAX_HEIGHT;
	localparam int CELL_AW       = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
	localparam int MW_W          = $clog2(MAX_WIDTH + 1);
	localparam int MH_W          = $clog2(MAX_HEIGHT + 1);
	localparam int OCC_THRESHOLD = 50;
	localparam int DIR_SHIFT     = 14;
	localparam int DIV_W         = 50;

	localparam logic [31:0] CELL_SIZE_RESET  = 32'd3277;
	localparam logic [9:0]  MAP_WIDTH_RESET  = 10'd512;
	localparam logic [9:0]  MAP_HEIGHT_RESET = 10'd512;

	typedef enum logic [2:0] {
		REG_ORG_X      = 3'd0,
		REG_ORG_Y      = 3'd1,
		REG_CELL_SIZE  = 3'd2,
		REG_MAP_WIDTH  = 3'd3,
		REG_MAP_HEIGHT = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic               is_cast;
		logic [17:0]        cell_number;
		logic               occupied;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [31:0]        range_limit;
	} item_t;

endpackage

FILE: src/ogrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogrc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ogrc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: src/ogrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogrc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ogrc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ogrc_pkg::DIV_W-1:0] dividend,
	input  logic [31:0]               divisor,
	output logic                      done,
	output logic [ogrc_pkg::DIV_W-1:0] quotient,
	output logic [31:0]               remainder
);
	import ogrc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [32:0]      rem_q;
	logic [31:0]      divisor_q;
	logic [32:0]      trial;
	logic [32:0]      diff;
	logic             ge;

	assign trial = {rem_q[31:0], quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff : trial;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[31:0];
endmodule

FILE: src/ogrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogrc_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ogrc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                func,
	input  logic [17:0]         cell_number,
	input  logic signed [7:0]   occupancy,
	input  logic signed [31:0]  start_x,
	input  logic signed [31:0]  start_y,
	input  logic signed [15:0]  dir_x,
	input  logic signed [15:0]  dir_y,
	input  logic [31:0]         range_limit,
	output logic                q_valid,
	output ogrc_pkg::item_t     q_item,
	input  logic                q_pop
);
	import ogrc_pkg::*;

	item_t      buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      in_item;
	logic       push;

	always_comb begin
		in_item.is_cast     = func;
		in_item.cell_number = cell_number;
		in_item.occupied    = $signed(occupancy) > $signed(8'(OCC_THRESHOLD));
		in_item.start_x     = start_x;
		in_item.start_y     = start_y;
		in_item.dir_x       = dir_x;
		in_item.dir_y       = dir_y;
		in_item.range_limit = range_limit;
	end

	assign item_stall = count_q == 2'd2;
	assign push       = item_valid && !item_stall;
	assign q_valid    = count_q != 2'd0;
	assign q_item     = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: src/ogrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogrc_back
// Executes queued words: map writes and grid ray walks, with result register.
// ----------------------------------------------------------------------------
module ogrc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ogrc_pkg::item_t    q_item,
	output logic               q_pop,
	input  logic signed [31:0] map_org_x,
	input  logic signed [31:0] map_org_y,
	input  logic [31:0]        cell_size,
	input  logic [9:0]         map_width,
	input  logic [9:0]         map_height,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        range,
	output logic               hit
);
	import ogrc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LAUNCH = 6'b000010,
		ST_WAIT   = 6'b000100,
		ST_BOUND  = 6'b001000,
		ST_TEST   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		PH_CX = 3'd0,
		PH_CY = 3'd1,
		PH_TX = 3'd2,
		PH_DX = 3'd3,
		PH_TY = 3'd4,
		PH_DY = 3'd5
	} phase_t;

	localparam int IDX_W = MH_W + MW_W + 1;

	state_t             state_q;
	phase_t             phase_q;
	phase_t             next_phase;
	logic               last_phase;
	logic signed [15:0] dx_q, dy_q;
	logic [31:0]        limit_q;
	logic signed [32:0] dpx_q, dpy_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] rx_q, ry_q;
	logic signed [63:0] tx_q, ty_q, ddx_q, ddy_q, dist_q;
	logic [31:0]        pend_range_q;
	logic               pend_hit_q;
	logic               res_valid_q;
	logic [31:0]        range_q;
	logic               hit_q;

	logic [31:0]        cs_eff;
	logic [MW_W-1:0]    w_eff;
	logic [MH_W-1:0]    h_eff;
	logic               sx, sy;
	logic [15:0]        adx, ady;
	logic signed [33:0] numx, numy;
	logic [33:0]        mnumx, mnumy;
	logic [32:0]        mdpx, mdpy;
	logic [DIV_W-1:0]   div_dividend;
	logic [31:0]        div_divisor;
	logic               div_neg;
	logic               div_start;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [31:0]        div_rem;
	logic signed [63:0] qval;
	logic signed [32:0] rval;
	logic               in_map;
	logic               below_limit;
	logic [IDX_W-1:0]   idx_wide;
	logic               step_x;
	logic               load_out;
	logic               ram_we;
	logic [CELL_AW-1:0] ram_addr;
	logic               ram_rdata;
	logic               wr_in_range;

	assign cs_eff = (cell_size == 32'd0) ? 32'd1 : cell_size;
	assign w_eff  = (32'(map_width) > 32'(MAX_WIDTH)) ? MW_W'(MAX_WIDTH) : MW_W'(map_width);
	assign h_eff  = (32'(map_height) > 32'(MAX_HEIGHT)) ? MH_W'(MAX_HEIGHT) : MH_W'(map_height);
	assign sx     = dx_q != 16'sd0;
	assign sy     = dy_q != 16'sd0;
	assign adx    = dx_q[15] ? 16'(-dx_q) : 16'(dx_q);
	assign ady    = dy_q[15] ? 16'(-dy_q) : 16'(dy_q);

	// offset to the next boundary from the start, using the start cell remainder
	assign numx  = !dx_q[15] ? $signed({2'b00, cs_eff}) - $signed({rx_q[32], rx_q})
		: $signed({rx_q[32], rx_q});
	assign numy  = !dy_q[15] ? $signed({2'b00, cs_eff}) - $signed({ry_q[32], ry_q})
		: $signed({ry_q[32], ry_q});
	assign mnumx = numx[33] ? 34'(-numx) : 34'(numx);
	assign mnumy = numy[33] ? 34'(-numy) : 34'(numy);
	assign mdpx  = dpx_q[32] ? 33'(-dpx_q) : 33'(dpx_q);
	assign mdpy  = dpy_q[32] ? 33'(-dpy_q) : 33'(dpy_q);

	always_comb begin
		unique case (phase_q)
			PH_CX: begin
				div_dividend = DIV_W'(mdpx);
				div_divisor  = cs_eff;
				div_neg      = dpx_q[32];
			end
			PH_CY: begin
				div_dividend = DIV_W'(mdpy);
				div_divisor  = cs_eff;
				div_neg      = dpy_q[32];
			end
			PH_TX: begin
				div_dividend = DIV_W'({mnumx, {DIR_SHIFT{1'b0}}});
				div_divisor  = 32'(adx);
				div_neg      = numx[33];
			end
			PH_DX: begin
				div_dividend = DIV_W'({cs_eff, {DIR_SHIFT{1'b0}}});
				div_divisor  = 32'(adx);
				div_neg      = 1'b0;
			end
			PH_TY: begin
				div_dividend = DIV_W'({mnumy, {DIR_SHIFT{1'b0}}});
				div_divisor  = 32'(ady);
				div_neg      = numy[33];
			end
			PH_DY: begin
				div_dividend = DIV_W'({cs_eff, {DIR_SHIFT{1'b0}}});
				div_divisor  = 32'(ady);
				div_neg      = 1'b0;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = 32'd1;
				div_neg      = 1'b0;
			end
		endcase
	end

	always_comb begin
		next_phase = PH_CY;
		last_phase = 1'b0;
		unique case (phase_q)
			PH_CX: next_phase = PH_CY;
			PH_CY: begin
				if (sx) begin
					next_phase = PH_TX;
				end else if (sy) begin
					next_phase = PH_TY;
				end else begin
					last_phase = 1'b1;
				end
			end
			PH_TX: next_phase = PH_DX;
			PH_DX: begin
				if (sy) begin
					next_phase = PH_TY;
				end else begin
					last_phase = 1'b1;
				end
			end
			PH_TY: next_phase = PH_DY;
			PH_DY: last_phase = 1'b1;
			default: last_phase = 1'b1;
		endcase
	end

	assign div_start = state_q == ST_LAUNCH;
	assign qval = div_neg ? -$signed(64'(div_quo)) : $signed(64'(div_quo));
	assign rval = div_neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});

	ogrc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign in_map = !cx_q[33] && (cx_q < $signed(34'(w_eff)))
		&& !cy_q[33] && (cy_q < $signed(34'(h_eff)));
	assign below_limit = dist_q < $signed({32'd0, limit_q});
	assign idx_wide = IDX_W'(cy_q[MH_W-1:0]) * IDX_W'(w_eff) + IDX_W'(cx_q[MW_W-1:0]);
	assign step_x = sx && (!sy || (tx_q < ty_q));

	assign q_pop       = (state_q == ST_IDLE) && q_valid;
	assign wr_in_range = 32'(q_item.cell_number) < 32'(MAP_CELLS);
	assign ram_we      = q_pop && !q_item.is_cast && wr_in_range;
	assign ram_addr    = (state_q == ST_IDLE) ? CELL_AW'(q_item.cell_number)
		: CELL_AW'(idx_wide);

	ogrc_ram #(
		.WIDTH (1),
		.DEPTH (MAP_CELLS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (q_item.occupied),
		.rdata (ram_rdata)
	);

	assign load_out = (state_q == ST_DONE) && (!res_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_CX;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.is_cast) begin
						phase_q <= PH_CX;
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						phase_q <= next_phase;
						state_q <= last_phase ? ST_BOUND : ST_LAUNCH;
					end
				end
				ST_BOUND: begin
					state_q <= (below_limit && in_map) ? ST_TEST : ST_DONE;
				end
				ST_TEST: begin
					state_q <= (ram_rdata || step_x || sy) ? (ram_rdata ? ST_DONE : ST_BOUND)
						: ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			range_q <= pend_range_q;
			hit_q   <= pend_hit_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				dx_q    <= q_item.dir_x;
				dy_q    <= q_item.dir_y;
				limit_q <= q_item.range_limit;
				dpx_q   <= $signed({q_item.start_x[31], q_item.start_x})
					- $signed({map_org_x[31], map_org_x});
				dpy_q   <= $signed({q_item.start_y[31], q_item.start_y})
					- $signed({map_org_y[31], map_org_y});
				dist_q  <= '0;
				tx_q    <= '0;
				ty_q    <= '0;
				ddx_q   <= '0;
				ddy_q   <= '0;
			end
			ST_WAIT: begin
				if (div_done) begin
					unique case (phase_q)
						PH_CX: begin
							cx_q <= qval[33:0];
							rx_q <= rval;
						end
						PH_CY: begin
							cy_q <= qval[33:0];
							ry_q <= rval;
						end
						PH_TX: tx_q <= qval;
						PH_DX: ddx_q <= qval;
						PH_TY: ty_q <= qval;
						PH_DY: ddy_q <= qval;
						default: ;
					endcase
				end
			end
			ST_BOUND: begin
				if (!(below_limit && in_map)) begin
					pend_range_q <= limit_q;
					pend_hit_q   <= 1'b0;
				end
			end
			ST_TEST: begin
				if (ram_rdata) begin
					pend_range_q <= dist_q[63] ? 32'd0 : dist_q[31:0];
					pend_hit_q   <= 1'b1;
				end else if (step_x) begin
					dist_q <= tx_q;
					tx_q   <= tx_q + ddx_q;
					cx_q   <= dx_q[15] ? cx_q - 34'sd1 : cx_q + 34'sd1;
				end else if (sy) begin
					dist_q <= ty_q;
					ty_q   <= ty_q + ddy_q;
					cy_q   <= dy_q[15] ? cy_q - 34'sd1 : cy_q + 34'sd1;
				end else begin
					pend_range_q <= limit_q;
					pend_hit_q   <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign range        = range_q;
	assign hit          = hit_q;
endmodule

FILE: src/occupancy_grid_ray_cast_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_cast_top
// Bit-per-cell occupancy grid with a cell-by-cell 2D ray walk.
// ----------------------------------------------------------------------------
// A map write (func 0) is done in the back end as it pops the word and gives no result.
// A cast (func 1) runs D serial divisions (2 for the start cell, plus 2 per
// nonzero direction axis) on the shared radix-2 divider, then visits N cells,
// each costing one map read and one step. The input side takes a word every
// cycle into a two-entry queue while the queue is not full, also while the
// back end works; map reads and writes share the single port of the grid
// memory, which has no reset.
module occupancy_grid_ray_cast_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               func,
	input  logic [17:0]        cell_number,
	input  logic signed [7:0]  occupancy,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic [31:0]        range_limit,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        range,
	output logic               hit,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import ogrc_pkg::*;

	logic signed [31:0] map_org_x_q;
	logic signed [31:0] map_org_y_q;
	logic [31:0]        cell_size_q;
	logic [9:0]         map_width_q;
	logic [9:0]         map_height_q;
	logic               cfg_wr;
	reg_index_t         cfg_sel;
	logic               q_valid;
	item_t              q_item;
	logic               q_pop;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = reg_index_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_org_x_q  <= '0;
			map_org_y_q  <= '0;
			cell_size_q  <= CELL_SIZE_RESET;
			map_width_q  <= MAP_WIDTH_RESET;
			map_height_q <= MAP_HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_ORG_X:      map_org_x_q  <= pwdata;
				REG_ORG_Y:      map_org_y_q  <= pwdata;
				REG_CELL_SIZE:  cell_size_q  <= pwdata;
				REG_MAP_WIDTH:  map_width_q  <= pwdata[9:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_ORG_X:      prdata = map_org_x_q;
			REG_ORG_Y:      prdata = map_org_y_q;
			REG_CELL_SIZE:  prdata = cell_size_q;
			REG_MAP_WIDTH:  prdata = 32'(map_width_q);
			REG_MAP_HEIGHT: prdata = 32'(map_height_q);
			default:        prdata = '0;
		endcase
	end

	ogrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.func        (func),
		.cell_number (cell_number),
		.occupancy   (occupancy),
		.start_x     (start_x),
		.start_y     (start_y),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.range_limit (range_limit),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	ogrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.map_org_x    (map_org_x_q),
		.map_org_y    (map_org_y_q),
		.cell_size    (cell_size_q),
		.map_width    (map_width_q),
		.map_height   (map_height_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.range        (range),
		.hit          (hit)
	);

	// back end never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) !q_valid |-> !q_pop)
		else $error("pop from empty queue");

	// a queued word stays until it is popped
	assert property (@(posedge clk) disable iff (!arst_n) q_valid && !q_pop |=> q_valid)
		else $error("queued word lost");

	// an empty queue always has room
	assert property (@(posedge clk) disable iff (!arst_n) !q_valid |-> !item_stall)
		else $error("stall with empty queue");
endmodule

FILE: sim/occupancy_grid_ray_cast_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_cast_top_tb
// Self-checking bench for the occupancy grid ray cast block.
// ----------------------------------------------------------------------------
// Map writes and ray casts go in through the item channel. A local grid model
// and ray walker predict each cast result, which is compared field by field
// as it leaves the block. The map registers are set over the APB port between
// phases, and every map cell a cast may read is written first. The sender and
// the receiver stall at random in three idle patterns.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_cast_top_tb;
	import ogrc_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int CYCLE_CAP  = 6000000;
	localparam int DRAIN_WAIT = 40;

	typedef struct {
		logic [31:0] range;
		logic        hit;
	} ray_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               func = 1'b0;
	logic [17:0]        cell_number = '0;
	logic signed [7:0]  occupancy = '0;
	logic signed [31:0] start_x = '0;
	logic signed [31:0] start_y = '0;
	logic signed [15:0] dir_x = '0;
	logic signed [15:0] dir_y = '0;
	logic [31:0]        range_limit = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [31:0]        range;
	logic               hit;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	occupancy_grid_ray_cast_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.func(func), .cell_number(cell_number), .occupancy(occupancy),
		.start_x(start_x), .start_y(start_y), .dir_x(dir_x), .dir_y(dir_y),
		.range_limit(range_limit),
		.result_valid(result_valid), .result_stall(result_stall),
		.range(range), .hit(hit),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// grid model and map settings
	bit                 occ_bits[MAP_CELLS];
	bit                 cell_written[MAP_CELLS];
	logic signed [31:0] org_x, org_y;
	logic [31:0]        cell_edge;
	logic [9:0]         map_w, map_h;

	ray_result_t pending_rays[$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	longint      cycles = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("occupancy_grid_ray_cast_top test failed");
			$finish;
		end
	end

	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		ray_result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_rays.size() == 0) begin
				$display("%0t: unexpected word range=%h hit=%b", $time, range, hit);
				errors++;
			end else begin
				exp_r = pending_rays.pop_front();
				if (range !== exp_r.range) begin
					$display("%0t: range expected %h actual %h", $time, exp_r.range, range);
					errors++;
				end
				if (hit !== exp_r.hit) begin
					$display("%0t: hit expected %b actual %b", $time, exp_r.hit, hit);
					errors++;
				end
			end
		end
	end

	function automatic int eff_width();
		return (map_w > MAX_WIDTH) ? MAX_WIDTH : int'(map_w);
	endfunction

	function automatic int eff_height();
		return (map_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(map_h);
	endfunction

	function automatic longint first_crossing(longint p, longint o, longint cs, longint c,
			longint d);
		longint mag, num;
		mag = (d < 0) ? -d : d;
		num = (d > 0) ? (o + (c + 1) * cs - p) : (p - o - c * cs);
		return (num * (longint'(1) << DIR_SHIFT)) / mag;
	endfunction

	function automatic ray_result_t walk_ray(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [15:0] dx, logic signed [15:0] dy, logic [31:0] lim);
		ray_result_t r;
		longint px, py, ox, oy, cs, w, h, cx, cy, tx, ty, ddx, ddy, stx, sty, walk_len, lm;
		bit step_x, step_y;
		px = sx; py = sy; ox = org_x; oy = org_y;
		cs = (cell_edge == 0) ? 1 : longint'(cell_edge);
		w = eff_width(); h = eff_height();
		lm = longint'(lim);
		cx = (px - ox) / cs;
		cy = (py - oy) / cs;
		step_x = (dx != 0);
		step_y = (dy != 0);
		stx = (dx > 0) ? 1 : -1;
		sty = (dy > 0) ? 1 : -1;
		tx = 0; ty = 0; ddx = 0; ddy = 0;
		if (step_x) begin
			tx = first_crossing(px, ox, cs, cx, dx);
			ddx = (cs * (longint'(1) << DIR_SHIFT)) / ((dx < 0) ? -longint'(dx) : longint'(dx));
		end
		if (step_y) begin
			ty = first_crossing(py, oy, cs, cy, dy);
			ddy = (cs * (longint'(1) << DIR_SHIFT)) / ((dy < 0) ? -longint'(dy) : longint'(dy));
		end
		walk_len = 0;
		r.range = lim;
		r.hit = 1'b0;
		while (walk_len < lm) begin
			if (cx < 0 || cx >= w || cy < 0 || cy >= h)
				break;
			if (occ_bits[cy * w + cx]) begin
				r.range = (walk_len < 0) ? 32'd0 : walk_len[31:0];
				r.hit = 1'b1;
				break;
			end
			if (step_x && (!step_y || tx < ty)) begin
				walk_len = tx; tx += ddx; cx += stx;
			end else if (step_y) begin
				walk_len = ty; ty += ddy; cy += sty;
			end else begin
				break;
			end
		end
		return r;
	endfunction

	task automatic send_item(logic f, logic [17:0] cn, logic signed [7:0] occ,
			logic signed [31:0] sx, logic signed [31:0] sy, logic signed [15:0] dx,
			logic signed [15:0] dy, logic [31:0] lim);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		func = f; cell_number = cn; occupancy = occ;
		start_x = sx; start_y = sy; dir_x = dx; dir_y = dy; range_limit = lim;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		if (!f) begin
			occ_bits[cn] = (occ > OCC_THRESHOLD);
			cell_written[cn] = 1'b1;
		end else begin
			pending_rays.insert(pending_rays.size(), walk_ray(sx, sy, dx, dy, lim));
		end
	endtask

	task automatic send_write(int idx, logic signed [7:0] occ);
		send_item(1'b0, idx[17:0], occ, $urandom, $urandom, 16'($urandom), 16'($urandom),
			$urandom);
	endtask

	task automatic send_cast(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [15:0] dx, logic signed [15:0] dy, logic [31:0] lim);
		send_item(1'b1, 18'($urandom), 8'($urandom), sx, sy, dx, dy, lim);
	endtask

	function automatic logic signed [7:0] rand_occupancy();
		if ($urandom_range(99) < 25)
			return 8'($urandom_range(127, 51));
		return 8'(int'($urandom_range(178, 0)) - 128);
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_rays.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic reg_write(reg_index_t idx, logic [31:0] val);
		logic [31:0] mask;
		mask = (idx == REG_MAP_WIDTH || idx == REG_MAP_HEIGHT) ? 32'h3ff : 32'hffff_ffff;
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ORG_X:      org_x = val;
			REG_ORG_Y:      org_y = val;
			REG_CELL_SIZE:  cell_edge = val;
			REG_MAP_WIDTH:  map_w = val[9:0];
			REG_MAP_HEIGHT: map_h = val[9:0];
			default: ;
		endcase
		@(negedge clk);
		pwrite = 1'b0; penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (val & mask)) begin
			$display("%0t: reg %0d expected %h actual %h", $time, idx, val & mask,
				prdata & mask);
			errors++;
		end
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	task automatic set_map(logic [31:0] ox, logic [31:0] oy, logic [31:0] cs,
			logic [9:0] w, logic [9:0] h);
		wait_idle();
		reg_write(REG_ORG_X, ox);
		reg_write(REG_ORG_Y, oy);
		reg_write(REG_CELL_SIZE, cs);
		reg_write(REG_MAP_WIDTH, {22'd0, w});
		reg_write(REG_MAP_HEIGHT, {22'd0, h});
	endtask

	// every cell a cast can read gets written first
	task automatic fill_map();
		int n;
		n = eff_width() * eff_height();
		for (int i = 0; i < n; i++)
			if (!cell_written[i])
				send_write(i, rand_occupancy());
	endtask

	function automatic logic signed [15:0] rand_dir();
		case ($urandom_range(9))
			0: return 16'sd0;
			1: return -16'sd32768;
			2: return 16'sd32767;
			3: return 16'(int'($urandom_range(15, 0)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_start(logic signed [31:0] o, int cells);
		longint cs, span;
		if ($urandom_range(99) < 12)
			return $urandom;
		cs = (cell_edge == 0) ? 1 : longint'(cell_edge);
		span = (cells + 2) * cs;
		return 32'(longint'(o) - cs + ((longint'({$urandom, $urandom})
			& 64'h7fff_ffff_ffff_ffff) % span));
	endfunction

	function automatic logic [31:0] rand_limit();
		longint cs, v;
		cs = (cell_edge == 0) ? 1 : longint'(cell_edge);
		v = longint'($urandom) % ((eff_width() + eff_height() + 1) * cs);
		case ($urandom_range(9))
			0: return 32'd0;
			1, 2: return 32'hffff_ffff;
			3: return $urandom;
			default: return (v > 64'hffff_ffff) ? 32'hffff_ffff : 32'(v);
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] one;
		one = 32'h1_0000;
		set_map(32'd0, 32'd0, one, 10'd4, 10'd4);
		for (int i = 0; i < 16; i++)
			send_write(i, (i == 5 || i == 14) ? 8'sd51 : 8'sd50);
		send_write(10, 8'sd127);
		send_write(6, -8'sd128);
		send_write(262143, 8'sd127);
		send_cast(32'h8000, 32'h8000, 16'sd16384, 16'sd0, 32'hffff_ffff);
		send_cast(32'h8000, 32'h8000, 16'sd0, 16'sd16384, 32'hffff_ffff);
		send_cast(32'h8000, 32'h8000, 16'sd11585, 16'sd11585, 32'hffff_ffff);
		send_cast(32'h1_8000, 32'h1_8000, 16'sd0, 16'sd0, 32'hffff_ffff);
		send_cast(32'h8000, 32'h8000, 16'sd0, 16'sd0, 32'hffff_ffff);
		send_cast(32'h1_8000, 32'h1_8000, 16'sd0, 16'sd0, 32'd0);
		send_cast(32'h3_8000, 32'h3_8000, -16'sd32768, -16'sd32768, 32'hffff_ffff);
		send_cast(32'h3_8000, 32'h0_8000, 16'sd32767, 16'sd1, 32'h2_0000);
		send_cast(-32'sh1_0000, 32'h2_8000, 16'sd16384, 16'sd0, 32'hffff_ffff);
		send_cast(32'h7fff_ffff, 32'h8000_0000, 16'sd100, -16'sd100, 32'hffff_ffff);
		send_cast(32'h0_8000, 32'h3_8000, 16'sd1, -16'sd1, 32'hffff_ffff);
		// zero-sized map and saturated size
		set_map(32'd0, 32'd0, 32'd0, 10'd0, 10'd1023);
		send_cast(32'd0, 32'd0, 16'sd16384, 16'sd16384, 32'hffff_ffff);
		set_map(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 10'd1023, 10'd1);
		fill_map();
		send_cast(32'h8000_0000, 32'h7fff_ffff, 16'sd9, 16'sd3, 32'hffff_ffff);
	endtask

	task automatic run_random_phase(int count);
		logic [31:0] cs, ox, oy;
		logic [9:0]  w, h;
		case ($urandom_range(9))
			0: cs = 32'd1;
			1: cs = 32'd0;
			2: cs = 32'hffff_ffff;
			3: cs = $urandom;
			default: cs = $urandom_range(32'h4_0000, 32'h100);
		endcase
		case ($urandom_range(6))
			0: ox = 32'h8000_0000;
			1: ox = 32'h7fff_ffff;
			2: ox = $urandom;
			default: ox = $urandom_range(32'h20_0000) - 32'h10_0000;
		endcase
		oy = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h20_0000) - 32'h10_0000;
		case ($urandom_range(11))
			0: begin w = 10'd512; h = 10'd1; end
			1: begin w = 10'd1; h = 10'd512; end
			2: begin w = 10'd1023; h = 10'($urandom_range(1, 0)); end
			3: begin w = 10'($urandom_range(1, 0)); h = 10'($urandom_range(1023, 513)); end
			default: begin
				w = 10'($urandom_range(16, 1));
				h = 10'($urandom_range(16, 1));
			end
		endcase
		set_map(ox, oy, cs, w, h);
		fill_map();
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(3) == 0)
					send_write($urandom_range(MAP_CELLS - 1), rand_occupancy());
				else if (eff_width() * eff_height() > 0)
					send_write($urandom_range(eff_width() * eff_height() - 1), rand_occupancy());
			end else begin
				send_cast(rand_start(org_x, eff_width()), rand_start(org_y, eff_height()),
					rand_dir(), rand_dir(), rand_limit());
			end
		end
	endtask

	task automatic test_random(int s_pct, int r_pct, int phases);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int p = 0; p < phases; p++)
			run_random_phase(20);
	endtask

	initial begin
		org_x = '0; org_y = '0;
		cell_edge = CELL_SIZE_RESET;
		map_w = MAP_WIDTH_RESET; map_h = MAP_HEIGHT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(12, 50, 6);
		test_random(50, 12, 6);
		test_random(0, 0, 6);
		wait_idle();
		if (errors == 0)
			$display("occupancy_grid_ray_cast_top test passed");
		else
			$display("occupancy_grid_ray_cast_top test failed");
		$finish;
	end

endmodule
